>>> rtl/core/trd_pkg.sv
package trd_pkg;

   // Pixel and packet limits
   localparam int unsigned MAX_PIXEL_BYTES   = 4;
   localparam int unsigned MAX_PACKET_PIXELS = 128;

   // Field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned BPP_W    = 3;
   localparam int unsigned TOTAL_W  = 30;
   localparam int unsigned PIXEL_W  = 32;
   localparam int unsigned REPEAT_W = 8;
   localparam int unsigned POS_W    = 2;

   // Packet header fields
   localparam logic [7:0] RUN_FLAG   = 8'h80;
   localparam logic [6:0] COUNT_MASK = 7'd127;

   // Register indexes on the configuration port
   localparam logic REG_BYTES_PER_PIXEL = 1'b0;
   localparam logic REG_PIXEL_TOTAL     = 1'b1;

   // Decoder phase, one-hot
   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_PIXEL  = 3'b010,
      PH_IGNORE = 3'b100
   } phase_type;

   // One result transaction
   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel_value;
      logic [REPEAT_W-1:0] repeat_count;
      logic                image_done;
      logic                decode_error;
   } trd_result_type;

endpackage

>>> rtl/core/tga_rle_pixel_decoder.sv
// TGA run-length pixel decoder.
// Input channel (req_): one compressed byte per transaction, with
// req_stream_end marking the last byte of the stream. Result channel (rsp_):
// one transaction per completed pixel, with the packed pixel (first byte
// lowest) and its repeat count; errors come as a zero-count transaction with
// rsp_image_done and rsp_decode_error set.
// Configuration: APB-style write of bytes_per_pixel at 0x0 and pixel_total
// at 0x4, done by the user only while the block is idle; the block does not
// enforce this. Reads return the registers. Throughput: one byte per cycle
// while req_stall is low. Each result is registered in the output buffer.
// Stall: a two-entry output buffer holds results; while the receiver stalls,
// bytes are still taken until a second result is waiting, and req_stall is
// high for as long as that second entry is held.
// Reset: decoder returns to expecting a packet header, counters clear,
// bytes_per_pixel returns to 4 and pixel_total to 1, and the output empties.
module tga_rle_pixel_decoder (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_code_byte,
   input  logic        req_stream_end,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_value,
   output logic [7:0]  rsp_repeat_count,
   output logic        rsp_image_done,
   output logic        rsp_decode_error,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [trd_pkg::BPP_W-1:0]   bpp_ff, bpp_in;
   logic [trd_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                        cfg_write;
   logic                        accept;
   logic                        res_valid;
   trd_pkg::trd_result_type     res;
   trd_pkg::trd_result_type     rsp_data;

   // Configuration registers
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      bpp_in   = bpp_ff;
      total_in = total_ff;
      if (cfg_write) begin
         unique case (paddr[2])
            trd_pkg::REG_BYTES_PER_PIXEL: bpp_in   = pwdata[trd_pkg::BPP_W-1:0];
            trd_pkg::REG_PIXEL_TOTAL:     total_in = pwdata[trd_pkg::TOTAL_W-1:0];
            default:                      bpp_in   = bpp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= trd_pkg::BPP_W'(4);
         total_ff <= trd_pkg::TOTAL_W'(1);
      end else begin
         bpp_ff   <= bpp_in;
         total_ff <= total_in;
      end
   end

   // Register read
   always_comb begin
      unique case (paddr[2])
         trd_pkg::REG_BYTES_PER_PIXEL: prdata = {29'd0, bpp_ff};
         trd_pkg::REG_PIXEL_TOTAL:     prdata = {2'd0, total_ff};
         default:                      prdata = '0;
      endcase
   end

   // Byte decode
   assign accept = req_valid && !req_stall;

   trd_step u_step (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .code_byte       (req_code_byte),
      .stream_end      (req_stream_end),
      .bytes_per_pixel (bpp_ff),
      .pixel_total     (total_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   // Output buffer
   trd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (req_stall)
   );

   assign rsp_pixel_value  = rsp_data.pixel_value;
   assign rsp_repeat_count = rsp_data.repeat_count;
   assign rsp_image_done   = rsp_data.image_done;
   assign rsp_decode_error = rsp_data.decode_error;

   // Checks
   a_stall_has_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_decode_error) |-> (rsp_image_done && (rsp_repeat_count == 8'd0)))
      else $error("error result with count or without done");

   a_pixel_count_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_decode_error) |->
         ((rsp_repeat_count != 8'd0) && (rsp_repeat_count <= 8'd128)))
      else $error("pixel result with repeat count out of range");

endmodule

>>> rtl/core/trd_step.sv
module trd_step (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [trd_pkg::BYTE_W-1:0]     code_byte,
   input  logic                           stream_end,
   input  logic [trd_pkg::BPP_W-1:0]      bytes_per_pixel,
   input  logic [trd_pkg::TOTAL_W-1:0]    pixel_total,
   output logic                           res_valid,
   output trd_pkg::trd_result_type        res
);

   trd_pkg::phase_type                  phase_ff, phase_in;
   logic                                run_ff, run_in;
   logic [trd_pkg::REPEAT_W-1:0]        left_ff, left_in;
   logic [trd_pkg::POS_W-1:0]           pos_ff, pos_in;
   logic [trd_pkg::PIXEL_W-1:0]         asm_ff, asm_in;
   logic [trd_pkg::TOTAL_W-1:0]         written_ff, written_in;

   logic [trd_pkg::BPP_W-1:0]           bpp_clamped;
   logic [trd_pkg::REPEAT_W-1:0]        count;
   logic [trd_pkg::TOTAL_W:0]           header_sum;
   logic [trd_pkg::BPP_W-1:0]           pos_next;
   logic [trd_pkg::PIXEL_W-1:0]         asm_merged;
   logic [trd_pkg::REPEAT_W-1:0]        rep;
   logic [trd_pkg::REPEAT_W-1:0]        left_after;
   logic [trd_pkg::TOTAL_W-1:0]         written_after;
   logic                                do_rearm;

   // Byte width: zero acts as one, oversize clamps to the maximum
   always_comb begin
      if (bytes_per_pixel == '0) begin
         bpp_clamped = trd_pkg::BPP_W'(1);
      end else if (bytes_per_pixel > trd_pkg::BPP_W'(trd_pkg::MAX_PIXEL_BYTES)) begin
         bpp_clamped = trd_pkg::BPP_W'(trd_pkg::MAX_PIXEL_BYTES);
      end else begin
         bpp_clamped = bytes_per_pixel;
      end
   end

   // Datapath terms for the header and pixel phases
   assign count      = {1'b0, code_byte[6:0] & trd_pkg::COUNT_MASK} + 8'd1;
   assign header_sum = {1'b0, written_ff} + {23'd0, count};
   assign pos_next   = {1'b0, pos_ff} + 3'd1;
   assign asm_merged = asm_ff | ({24'd0, code_byte} << {pos_ff, 3'b000});
   assign rep        = run_ff ? left_ff : 8'd1;
   assign left_after = run_ff ? 8'd0 : ((left_ff != '0) ? left_ff - 8'd1 : 8'd0);
   assign written_after = written_ff + {22'd0, rep};

   // Next state and result
   always_comb begin
      phase_in   = phase_ff;
      run_in     = run_ff;
      left_in    = left_ff;
      pos_in     = pos_ff;
      asm_in     = asm_ff;
      written_in = written_ff;
      do_rearm   = 1'b0;
      res_valid  = 1'b0;
      res        = '0;

      if (accept) begin
         unique case (phase_ff)
            trd_pkg::PH_HEADER: begin
               if (stream_end || (header_sum > {1'b0, pixel_total})) begin
                  // header as last byte, or a packet past the image end
                  do_rearm         = 1'b1;
                  phase_in         = stream_end ? trd_pkg::PH_HEADER : trd_pkg::PH_IGNORE;
                  res_valid        = 1'b1;
                  res.image_done   = 1'b1;
                  res.decode_error = 1'b1;
               end else begin
                  phase_in = trd_pkg::PH_PIXEL;
                  run_in   = (code_byte & trd_pkg::RUN_FLAG) != '0;
                  left_in  = count;
                  pos_in   = '0;
                  asm_in   = '0;
               end
            end
            trd_pkg::PH_PIXEL: begin
               if (pos_next < bpp_clamped) begin
                  // more bytes of this pixel to come
                  pos_in = pos_next[trd_pkg::POS_W-1:0];
                  asm_in = asm_merged;
                  if (stream_end) begin
                     do_rearm         = 1'b1;
                     phase_in         = trd_pkg::PH_HEADER;
                     res_valid        = 1'b1;
                     res.image_done   = 1'b1;
                     res.decode_error = 1'b1;
                  end
               end else if (written_after == pixel_total) begin
                  // pixel completes the image
                  do_rearm         = 1'b1;
                  phase_in         = stream_end ? trd_pkg::PH_HEADER : trd_pkg::PH_IGNORE;
                  res_valid        = 1'b1;
                  res.pixel_value  = asm_merged;
                  res.repeat_count = rep;
                  res.image_done   = 1'b1;
               end else if (stream_end) begin
                  // stream ends before the image is full
                  do_rearm         = 1'b1;
                  phase_in         = trd_pkg::PH_HEADER;
                  res_valid        = 1'b1;
                  res.image_done   = 1'b1;
                  res.decode_error = 1'b1;
               end else begin
                  phase_in         = (left_after != '0) ? trd_pkg::PH_PIXEL : trd_pkg::PH_HEADER;
                  left_in          = left_after;
                  pos_in           = '0;
                  asm_in           = '0;
                  written_in       = written_after;
                  res_valid        = 1'b1;
                  res.pixel_value  = asm_merged;
                  res.repeat_count = rep;
               end
            end
            trd_pkg::PH_IGNORE: begin
               if (stream_end) begin
                  do_rearm = 1'b1;
                  phase_in = trd_pkg::PH_HEADER;
               end
            end
            default: begin
               if (stream_end) begin
                  do_rearm = 1'b1;
                  phase_in = trd_pkg::PH_HEADER;
               end
            end
         endcase
      end

      // re-arm for a new image
      if (do_rearm) begin
         run_in     = 1'b0;
         left_in    = '0;
         pos_in     = '0;
         asm_in     = '0;
         written_in = '0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= trd_pkg::PH_HEADER;
         run_ff     <= 1'b0;
         left_ff    <= '0;
         pos_ff     <= '0;
         asm_ff     <= '0;
         written_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         run_ff     <= run_in;
         left_ff    <= left_in;
         pos_ff     <= pos_in;
         asm_ff     <= asm_in;
         written_ff <= written_in;
      end
   end

endmodule

>>> rtl/core/trd_skid.sv
module trd_skid (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  trd_pkg::trd_result_type push_data,
   input  logic                    out_stall,
   output logic                    out_valid,
   output trd_pkg::trd_result_type out_data,
   output logic                    full
);

   logic                    out_valid_ff, out_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   trd_pkg::trd_result_type out_data_ff, out_data_in;
   trd_pkg::trd_result_type skid_data_ff, skid_data_in;
   logic                    pop;

   assign pop = out_valid_ff && !out_stall;

   // Output slot refills from the skid slot first, then from new results
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

>>> dv/tb_tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder;

   // One compressed byte as queued for the driver
   typedef struct packed {
      logic [trd_pkg::BYTE_W-1:0] code_byte;
      logic                       stream_end;
   } stream_byte_type;

   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned BYTE_GOAL    = 1080;
   localparam logic [trd_pkg::TOTAL_W-1:0] TOTAL_HIGH = 30'd1073676289;
   localparam logic [trd_pkg::TOTAL_W-1:0] TOTAL_ALL  = 30'h3FFFFFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_code_byte  = '0;
   logic        req_stream_end = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pixel_value;
   logic [7:0]  rsp_repeat_count;
   logic        rsp_image_done;
   logic        rsp_decode_error;

   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [2:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   // Shadow registers and decoder state of the predictor
   logic [trd_pkg::BPP_W-1:0]   cfg_bpp      = 3'd4;
   logic [trd_pkg::TOTAL_W-1:0] cfg_total    = 30'd1;
   trd_pkg::phase_type          dec_phase    = trd_pkg::PH_HEADER;
   logic                        dec_is_run   = 1'b0;
   logic [7:0]                  dec_left     = '0;
   logic [trd_pkg::POS_W-1:0]   dec_pos      = '0;
   logic [trd_pkg::PIXEL_W-1:0] dec_assembly = '0;
   logic [trd_pkg::TOTAL_W-1:0] dec_written  = '0;

   stream_byte_type          byte_queue[$];
   trd_pkg::trd_result_type  pending_pixels[$];

   int unsigned bytes_queued   = 0;
   int unsigned bytes_taken    = 0;
   int unsigned gap_left       = 0;
   int unsigned stall_left     = 0;
   int unsigned idle_cycles    = 0;
   int          mismatch_count = 0;
   bit          quiet_mode     = 1'b0;

   tga_rle_pixel_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_byte    (req_code_byte),
      .req_stream_end   (req_stream_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_done   (rsp_image_done),
      .rsp_decode_error (rsp_decode_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #4 clock = ~clock;

   // Predictor
   function automatic void clear_decoder();
      dec_phase    = trd_pkg::PH_HEADER;
      dec_is_run   = 1'b0;
      dec_left     = '0;
      dec_pos      = '0;
      dec_assembly = '0;
      dec_written  = '0;
   endfunction

   function automatic void queue_pixel(input logic [trd_pkg::PIXEL_W-1:0] value,
                                       input logic [trd_pkg::REPEAT_W-1:0] rep,
                                       input logic done, input logic err);
      trd_pkg::trd_result_type r;
      r.pixel_value  = value;
      r.repeat_count = rep;
      r.image_done   = done;
      r.decode_error = err;
      pending_pixels.push_back(r);
   endfunction

   // error transaction; unless this is the last byte, drop bytes until it comes
   function automatic void flag_decode_error(input logic last);
      clear_decoder();
      if (!last) dec_phase = trd_pkg::PH_IGNORE;
      queue_pixel('0, '0, 1'b1, 1'b1);
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic last);
      logic [trd_pkg::BPP_W-1:0]    bpp;
      logic [7:0]                   count;
      logic [trd_pkg::REPEAT_W-1:0] rep;
      logic [trd_pkg::PIXEL_W-1:0]  value;
      bpp = cfg_bpp;
      if (bpp == 0) bpp = 3'd1;
      if (bpp > trd_pkg::MAX_PIXEL_BYTES) bpp = trd_pkg::BPP_W'(trd_pkg::MAX_PIXEL_BYTES);
      case (dec_phase)
         trd_pkg::PH_HEADER: begin
            count = {1'b0, b[6:0]} + 8'd1;
            if (last || ({1'b0, dec_written} + 31'(count)) > {1'b0, cfg_total}) begin
               flag_decode_error(last);
            end else begin
               dec_phase    = trd_pkg::PH_PIXEL;
               dec_is_run   = (b & trd_pkg::RUN_FLAG) != 0;
               dec_left     = count;
               dec_pos      = '0;
               dec_assembly = '0;
            end
         end
         trd_pkg::PH_PIXEL: begin
            dec_assembly = dec_assembly | (32'(b) << (8 * dec_pos));
            if (({1'b0, dec_pos} + 3'd1) < bpp) begin
               dec_pos = dec_pos + 2'd1;
               if (last) flag_decode_error(1'b1);
            end else begin
               if (dec_is_run) begin
                  rep      = dec_left;
                  dec_left = '0;
               end else begin
                  rep = 8'd1;
                  if (dec_left != 0) dec_left = dec_left - 8'd1;
               end
               value        = dec_assembly;
               dec_assembly = '0;
               dec_pos      = '0;
               dec_written  = dec_written + trd_pkg::TOTAL_W'(rep);
               if (dec_written == cfg_total) begin
                  clear_decoder();
                  if (!last) dec_phase = trd_pkg::PH_IGNORE;
                  queue_pixel(value, rep, 1'b1, 1'b0);
               end else if (last) begin
                  flag_decode_error(1'b1);
               end else begin
                  dec_phase = (dec_left != 0) ? trd_pkg::PH_PIXEL : trd_pkg::PH_HEADER;
                  queue_pixel(value, rep, 1'b0, 1'b0);
               end
            end
         end
         default: begin
            if (last) clear_decoder();
         end
      endcase
   endfunction

   // Input driver: presents queued bytes, random gaps between transactions
   always @(posedge clock) begin : byte_driver
      stream_byte_type next_byte;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_code_byte, req_stream_end);
            bytes_taken++;
         end
         // a stalled transaction stays on the bus untouched
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               next_byte = byte_queue.pop_front();
               req_code_byte  <= next_byte.code_byte;
               req_stream_end <= next_byte.stream_end;
               req_valid      <= 1'b1;
               if (!quiet_mode && $urandom_range(0, 11) == 0) gap_left = $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Result monitor: compares against the oldest expected pixel, random stall bursts
   always @(posedge clock) begin : result_monitor
      trd_pkg::trd_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               $display({"%0t: unexpected result, expected none, ",
                         "actual pixel %h repeat %0d done %b error %b"},
                        $time, rsp_pixel_value, rsp_repeat_count, rsp_image_done,
                        rsp_decode_error);
               mismatch_count++;
            end else begin
               want = pending_pixels.pop_front();
               check_field("pixel_value", want.pixel_value, rsp_pixel_value);
               check_field("repeat_count", 32'(want.repeat_count), 32'(rsp_repeat_count));
               check_field("image_done", 32'(want.image_done), 32'(rsp_image_done));
               check_field("decode_error", 32'(want.decode_error), 32'(rsp_decode_error));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_mode && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus helpers
   function automatic void queue_byte(input logic [7:0] b, input logic last);
      byte_queue.push_back('{b, last});
      bytes_queued++;
   endfunction

   // wait until every byte is taken and every pixel is back, then let the pipe drain
   task automatic settle();
      while (bytes_taken != bytes_queued || pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == trd_pkg::REG_BYTES_PER_PIXEL) cfg_bpp = data[trd_pkg::BPP_W-1:0];
      else cfg_total = data[trd_pkg::TOTAL_W-1:0];
   endtask

   // Random bytes, stream_end scattered, always closed by a stream_end
   function automatic void queue_noise();
      int unsigned n;
      n = $urandom_range(3, 20);
      repeat (n - 1) queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
      queue_byte(8'($urandom), 1'b1);
   endfunction

   // Image stream for the current settings.
   // mode 1: overruns the image, 2: cut short, 3: trailing bytes, else clean
   function automatic void queue_image(input int unsigned mode);
      stream_byte_type seq[$];
      int unsigned     bpp_eff, npix, left, cnt, cut;
      logic            run;
      bpp_eff = (cfg_bpp == 0) ? 1 :
                (cfg_bpp > trd_pkg::MAX_PIXEL_BYTES) ? trd_pkg::MAX_PIXEL_BYTES : cfg_bpp;
      // huge images are never filled: the stream ends early
      npix = (cfg_total <= 48) ? cfg_total : $urandom_range(1, 30);
      if (mode == 1) npix += $urandom_range(1, 4);
      left = npix;
      while (left > 0) begin
         if ($urandom_range(0, 7) == 0) cnt = $urandom_range(1, (left < 128) ? left : 128);
         else cnt = $urandom_range(1, (left < 6) ? left : 6);
         run = $urandom_range(0, 1);
         seq.push_back('{{run, 7'(cnt - 1)}, 1'b0});
         repeat (run ? 1 : cnt) begin
            repeat (bpp_eff) seq.push_back('{8'($urandom), 1'b0});
         end
         left -= cnt;
      end
      if (mode == 2 && seq.size() > 1) begin
         cut = $urandom_range(1, seq.size() - 1);
         repeat (cut) void'(seq.pop_back());
      end
      if (mode == 3) repeat ($urandom_range(1, 4)) seq.push_back('{8'($urandom), 1'b0});
      if (seq.size() == 0) seq.push_back('{8'($urandom), 1'b0});
      seq[$].stream_end = 1'b1;
      foreach (seq[i]) queue_byte(seq[i].code_byte, seq[i].stream_end);
   endfunction

   // Stimulus
   initial begin : stimulus
      logic [trd_pkg::BPP_W-1:0]   bpp;
      logic [trd_pkg::TOTAL_W-1:0] total;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one 4-byte pixel
      queue_byte(trd_pkg::RUN_FLAG, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hA5, 1'b0);
      queue_byte(8'h5A, 1'b1);
      settle();

      // longest run, then a raw packet overrunning the image, bytes dropped to the end
      write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'd1);
      write_reg(trd_pkg::REG_PIXEL_TOTAL, 32'd200);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h33, 1'b0);
      queue_byte(8'hCC, 1'b1);
      // header as the last byte
      queue_byte(8'h00, 1'b1);
      settle();

      // pixel cut off by the last byte
      write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'd3);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h11, 1'b0);
      queue_byte(8'h22, 1'b1);
      settle();

      // zero pixel total: the first header overruns
      write_reg(trd_pkg::REG_PIXEL_TOTAL, 32'd0);
      queue_byte(8'h85, 1'b0);
      queue_byte(8'h00, 1'b1);
      settle();

      // width 0 acts as 1; image done, then a trailing byte before the end
      write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'd0);
      write_reg(trd_pkg::REG_PIXEL_TOTAL, 32'd2);
      queue_byte(8'h81, 1'b0);
      queue_byte(8'h7E, 1'b0);
      queue_byte(8'h44, 1'b0);
      queue_byte(8'h55, 1'b1);
      settle();

      // width 7 acts as 4
      write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'd7);
      write_reg(trd_pkg::REG_PIXEL_TOTAL, 32'd1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'hFE, 1'b1);

      // random phases, each of which may write new settings
      while (bytes_queued < BYTE_GOAL) begin
         settle();
         if (bytes_queued > BYTE_GOAL - 150) quiet_mode = 1'b1;
         case ($urandom_range(0, 9))
            0:       bpp = 3'd0;
            1:       bpp = 3'($urandom_range(5, 7));
            default: bpp = 3'($urandom_range(1, 4));
         endcase
         case ($urandom_range(0, 15))
            0:       total = '0;
            1:       total = TOTAL_HIGH;
            2:       total = TOTAL_ALL;
            3:       total = trd_pkg::TOTAL_W'($urandom);
            default: total = trd_pkg::TOTAL_W'($urandom_range(1, 24));
         endcase
         if ($urandom_range(0, 3) != 0) write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'(bpp));
         if ($urandom_range(0, 3) != 0) write_reg(trd_pkg::REG_PIXEL_TOTAL, 32'(total));
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            else queue_image($urandom_range(1, 9));
            // sender sometimes holds off until every pixel is back
            if ($urandom_range(0, 7) == 0) settle();
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
